FILE: rtl/core/fse_pkg.sv
// fse_pkg: shared types and constants for the fasta subsequence extract unit
// used by fse_window and fasta_subsequence_extract_unit; no dependencies
package fse_pkg;

    localparam int POSITION_BITS = 32;
    localparam int CFG_DATA_W    = 32;
    localparam int CFG_IDX_W     = 1;
    localparam int RECORD_W      = 32;
    localparam int BYTE_W        = 8;
    // compare width covers both the position counter and the window bounds
    localparam int CMP_W = (POSITION_BITS > CFG_DATA_W) ? POSITION_BITS : CFG_DATA_W;

    localparam logic [CFG_IDX_W-1:0] REG_BEGIN_POS = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_END_POS   = CFG_IDX_W'(1);

    localparam logic [BYTE_W-1:0] CHAR_GT = 8'h3E;
    localparam logic [BYTE_W-1:0] CHAR_LF = 8'h0A;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] lo;
        logic [CFG_DATA_W-1:0] hi;
        logic [CFG_DATA_W-1:0] hi_m1;
    } t_window;

endpackage

FILE: rtl/core/fse_window.sv
// fse_window: begin/end configuration registers with ordered window bounds
// bounds are sorted at write time so the byte path sees plain registers
// depends on fse_pkg
module fse_window (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [fse_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [fse_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output fse_pkg::t_window                o_window
);

    logic [fse_pkg::CFG_DATA_W-1:0] r_begin;
    logic [fse_pkg::CFG_DATA_W-1:0] r_end;
    fse_pkg::t_window               r_window;

    logic [fse_pkg::CFG_DATA_W-1:0] n_begin;
    logic [fse_pkg::CFG_DATA_W-1:0] n_end;
    fse_pkg::t_window               n_window;

    always_comb begin
        n_begin = r_begin;
        n_end   = r_end;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                fse_pkg::REG_BEGIN_POS: n_begin = i_cfg_data;
                fse_pkg::REG_END_POS:   n_end   = i_cfg_data;
                default: ;
            endcase
        end
        if (n_begin <= n_end) begin
            n_window.lo = n_begin;
            n_window.hi = n_end;
        end else begin
            n_window.lo = n_end;
            n_window.hi = n_begin;
        end
        n_window.hi_m1 = n_window.hi - fse_pkg::CFG_DATA_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_begin  <= '0;
            r_end    <= '0;
            r_window <= '{lo: '0, hi: '0, hi_m1: '1};
        end else begin
            r_begin  <= n_begin;
            r_end    <= n_end;
            r_window <= n_window;
        end
    end

    assign o_window = r_window;

endmodule

FILE: rtl/core/fasta_subsequence_extract_unit.sv
// fasta_subsequence_extract_unit: one fasta text byte per beat in, window residues out
// result: registered, so a result appears on the output in the cycle after its byte is accepted
// throughput: one byte per cycle; input ready while the result register is empty or taken
// reset: synchronous active low; parse state and window registers return to their reset values
// position update, window compare and result select sit between parse state and result register
// depends on fse_pkg and fse_window
module fasta_subsequence_extract_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [fse_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [fse_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [fse_pkg::BYTE_W-1:0]      i_data_byte,
    input  logic                            i_stream_end,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [fse_pkg::BYTE_W-1:0]      o_out_byte,
    output logic                            o_byte_valid,
    output logic [fse_pkg::RECORD_W-1:0]    o_record_number,
    output logic                            o_first_of_extract,
    output logic                            o_last_of_extract,
    output logic                            o_complete
);

    fse_pkg::t_window window;

    fse_window u_window (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_window   (window)
    );

    // parse state
    logic                                r_in_header;
    logic                                r_at_line_start;
    logic [fse_pkg::POSITION_BITS-1:0]   r_pos;
    logic                                r_in_window;
    logic                                r_window_done;
    logic [fse_pkg::RECORD_W-1:0]        r_rec_count;
    logic                                r_record_open;

    logic                                n_in_header;
    logic                                n_at_line_start;
    logic [fse_pkg::POSITION_BITS-1:0]   n_pos;
    logic                                n_in_window;
    logic                                n_window_done;
    logic [fse_pkg::RECORD_W-1:0]        n_rec_count;
    logic                                n_record_open;

    // result register
    logic                                r_out_valid;
    logic [fse_pkg::BYTE_W-1:0]          r_out_byte;
    logic                                r_byte_valid;
    logic [fse_pkg::RECORD_W-1:0]        r_record_number;
    logic                                r_first;
    logic                                r_last;
    logic                                r_complete;

    logic                                emit;
    logic [fse_pkg::BYTE_W-1:0]          res_byte;
    logic                                res_valid;
    logic                                res_first;
    logic                                res_last;
    logic                                res_complete;

    logic                                accept;
    logic [fse_pkg::CMP_W-1:0]           pos_x;
    logic [fse_pkg::CMP_W-1:0]           lo_x;
    logic [fse_pkg::CMP_W-1:0]           hi_x;
    logic [fse_pkg::CMP_W-1:0]           hi_m1_x;
    logic                                hit;
    logic                                at_end;

    assign o_ready = !r_out_valid || i_ready;
    assign accept  = i_valid && o_ready;

    assign pos_x   = fse_pkg::CMP_W'(r_pos);
    assign lo_x    = fse_pkg::CMP_W'(window.lo);
    assign hi_x    = fse_pkg::CMP_W'(window.hi);
    assign hi_m1_x = fse_pkg::CMP_W'(window.hi_m1);
    assign hit     = !r_window_done && (pos_x >= lo_x) && (pos_x < hi_x);
    assign at_end  = (pos_x == hi_m1_x);

    always_comb begin
        n_in_header     = r_in_header;
        n_at_line_start = r_at_line_start;
        n_pos           = r_pos;
        n_in_window     = r_in_window;
        n_window_done   = r_window_done;
        n_rec_count     = r_rec_count;
        n_record_open   = r_record_open;
        emit            = 1'b0;
        res_byte        = '0;
        res_valid       = 1'b0;
        res_first       = 1'b0;
        res_last        = 1'b0;
        res_complete    = 1'b0;

        if (r_at_line_start && (i_data_byte == fse_pkg::CHAR_GT)) begin
            // new record closes an open window of the previous one early
            if (r_record_open && r_in_window) begin
                emit     = 1'b1;
                res_last = 1'b1;
            end
            if (r_record_open) begin
                n_rec_count = r_rec_count + fse_pkg::RECORD_W'(1);
            end
            n_record_open   = 1'b1;
            n_in_header     = 1'b1;
            n_at_line_start = 1'b0;
            n_pos           = fse_pkg::POSITION_BITS'(1);
            n_in_window     = 1'b0;
            n_window_done   = 1'b0;
        end else if (i_data_byte == fse_pkg::CHAR_LF) begin
            n_in_header     = 1'b0;
            n_at_line_start = 1'b1;
        end else begin
            n_at_line_start = 1'b0;
            if (!r_in_header && r_record_open) begin
                if (hit) begin
                    emit         = 1'b1;
                    res_byte     = i_data_byte;
                    res_valid    = 1'b1;
                    res_first    = !r_in_window;
                    res_last     = at_end || i_stream_end;
                    res_complete = at_end;
                    n_in_window  = !(at_end || i_stream_end);
                    if (at_end || i_stream_end) begin
                        n_window_done = 1'b1;
                    end
                end
                // saturate at the top of the position range
                if (r_pos != '1) begin
                    n_pos = r_pos + fse_pkg::POSITION_BITS'(1);
                end
            end
        end

        if (i_stream_end) begin
            if (!emit && r_record_open && n_in_window) begin
                emit     = 1'b1;
                res_last = 1'b1;
            end
            n_in_header     = 1'b0;
            n_at_line_start = 1'b1;
            n_pos           = fse_pkg::POSITION_BITS'(1);
            n_in_window     = 1'b0;
            n_window_done   = 1'b0;
            n_rec_count     = '0;
            n_record_open   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_header     <= 1'b0;
            r_at_line_start <= 1'b1;
            r_pos           <= fse_pkg::POSITION_BITS'(1);
            r_in_window     <= 1'b0;
            r_window_done   <= 1'b0;
            r_rec_count     <= '0;
            r_record_open   <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            if (accept) begin
                r_in_header     <= n_in_header;
                r_at_line_start <= n_at_line_start;
                r_pos           <= n_pos;
                r_in_window     <= n_in_window;
                r_window_done   <= n_window_done;
                r_rec_count     <= n_rec_count;
                r_record_open   <= n_record_open;
                r_out_valid     <= emit;
            end else if (i_ready) begin
                r_out_valid     <= 1'b0;
            end
        end
    end

    // payload needs no reset
    always_ff @(posedge i_clk) begin
        if (accept && emit) begin
            r_out_byte      <= res_byte;
            r_byte_valid    <= res_valid;
            r_record_number <= r_rec_count;
            r_first         <= res_first;
            r_last          <= res_last;
            r_complete      <= res_complete;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_out_byte         = r_out_byte;
    assign o_byte_valid       = r_byte_valid;
    assign o_record_number    = r_record_number;
    assign o_first_of_extract = r_first;
    assign o_last_of_extract  = r_last;
    assign o_complete         = r_complete;

endmodule

FILE: tb/fasta_subsequence_extract_unit_tb.sv
// fasta_subsequence_extract_unit_tb: self-checking bench for the fasta window extractor
// drives fasta text beats with random gaps and stalls, predicts each extract beat in-bench
// depends on fse_pkg and the fasta_subsequence_extract_unit rtl
module fasta_subsequence_extract_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fse_pkg::*;

    typedef struct packed {
        logic [BYTE_W-1:0]   out_byte;
        logic                byte_valid;
        logic [RECORD_W-1:0] record_number;
        logic                first_of_extract;
        logic                last_of_extract;
        logic                complete;
    } t_extract_beat;

    logic                  i_clk        = 1'b0;
    logic                  i_rst_n      = 1'b0;
    logic                  i_cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx    = REG_BEGIN_POS;
    logic [CFG_DATA_W-1:0] i_cfg_data   = '0;
    logic                  i_valid      = 1'b0;
    logic                  o_ready;
    logic [BYTE_W-1:0]     i_data_byte  = '0;
    logic                  i_stream_end = 1'b0;
    logic                  o_valid;
    logic                  i_ready      = 1'b0;
    logic [BYTE_W-1:0]     o_out_byte;
    logic                  o_byte_valid;
    logic [RECORD_W-1:0]   o_record_number;
    logic                  o_first_of_extract;
    logic                  o_last_of_extract;
    logic                  o_complete;

    fasta_subsequence_extract_unit dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_data         (i_cfg_data),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_data_byte        (i_data_byte),
        .i_stream_end       (i_stream_end),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_out_byte         (o_out_byte),
        .o_byte_valid       (o_byte_valid),
        .o_record_number    (o_record_number),
        .o_first_of_extract (o_first_of_extract),
        .o_last_of_extract  (o_last_of_extract),
        .o_complete         (o_complete)
    );

    // window registers as the block should hold them
    logic [CFG_DATA_W-1:0] win_begin = '0;
    logic [CFG_DATA_W-1:0] win_end   = '0;

    // parse state of the predictor
    logic                     hdr_active;
    logic                     line_start;
    logic [POSITION_BITS-1:0] res_pos;
    logic                     window_open;
    logic                     window_closed;
    logic [RECORD_W-1:0]      rec_count;
    logic                     rec_open;

    t_extract_beat pending_extract[$];

    int  err_count      = 0;
    int  beats_sent     = 0;
    int  results_seen   = 0;
    int  windows_used   = 0;
    bit  no_idle        = 1'b0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("[fasta_subsequence_extract_unit] ERROR");
        $finish;
    end

    // receiver side stalls
    always @(posedge i_clk) begin
        i_ready <= no_idle || ($urandom_range(0, 99) >= 22);
    end

    function automatic void clear_parse();
        hdr_active    = 1'b0;
        line_start    = 1'b1;
        res_pos       = POSITION_BITS'(1);
        window_open   = 1'b0;
        window_closed = 1'b0;
        rec_count     = '0;
        rec_open      = 1'b0;
    endfunction

    function automatic t_extract_beat make_beat(logic [BYTE_W-1:0] b, logic bv, logic fst,
                                                logic lst, logic cmp);
        t_extract_beat r;
        r.out_byte         = b;
        r.byte_valid       = bv;
        r.record_number    = rec_count;
        r.first_of_extract = fst;
        r.last_of_extract  = lst;
        r.complete         = cmp;
        return r;
    endfunction

    function automatic void predict_extract(logic [BYTE_W-1:0] b, logic se);
        logic [CMP_W-1:0] lo;
        logic [CMP_W-1:0] hi;
        logic [CMP_W-1:0] pos;
        logic             at_end;
        logic             lst;
        logic             emit;
        t_extract_beat    r;
        lo   = (win_begin <= win_end) ? CMP_W'(win_begin) : CMP_W'(win_end);
        hi   = (win_begin <= win_end) ? CMP_W'(win_end) : CMP_W'(win_begin);
        emit = 1'b0;
        r    = '0;
        if (line_start && b == CHAR_GT) begin
            // new record closes an open window of the previous one
            if (rec_open && window_open) begin
                r    = make_beat('0, 1'b0, 1'b0, 1'b1, 1'b0);
                emit = 1'b1;
            end
            if (rec_open) rec_count = rec_count + 1'b1;
            rec_open      = 1'b1;
            hdr_active    = 1'b1;
            line_start    = 1'b0;
            res_pos       = POSITION_BITS'(1);
            window_open   = 1'b0;
            window_closed = 1'b0;
        end else if (b == CHAR_LF) begin
            hdr_active = 1'b0;
            line_start = 1'b1;
        end else begin
            line_start = 1'b0;
            if (!hdr_active && rec_open) begin
                pos = CMP_W'(res_pos);
                if (!window_closed && pos >= lo && pos < hi) begin
                    at_end = (pos == hi - 1'b1);
                    lst    = at_end || se;
                    r      = make_beat(b, 1'b1, !window_open, lst, at_end);
                    emit   = 1'b1;
                    window_open = !lst;
                    if (lst) window_closed = 1'b1;
                end
                if (res_pos != '1) res_pos = res_pos + 1'b1;
            end
        end
        if (se) begin
            if (!emit && rec_open && window_open) begin
                r    = make_beat('0, 1'b0, 1'b0, 1'b1, 1'b0);
                emit = 1'b1;
            end
            clear_parse();
        end
        if (emit) pending_extract.push_back(r);
    endfunction

    function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            err_count++;
        end
    endfunction

    always @(posedge i_clk) begin : check_results
        t_extract_beat e;
        if (i_rst_n && o_valid && i_ready) begin
            results_seen++;
            if (pending_extract.size() == 0) begin
                $error("unexpected result beat: out_byte 0x%0h record %0d",
                       o_out_byte, o_record_number);
                err_count++;
            end else begin
                e = pending_extract.pop_front();
                check_field("out_byte", 32'(e.out_byte), 32'(o_out_byte));
                check_field("byte_valid", 32'(e.byte_valid), 32'(o_byte_valid));
                check_field("record_number", 32'(e.record_number), 32'(o_record_number));
                check_field("first_of_extract", 32'(e.first_of_extract),
                            32'(o_first_of_extract));
                check_field("last_of_extract", 32'(e.last_of_extract),
                            32'(o_last_of_extract));
                check_field("complete", 32'(e.complete), 32'(o_complete));
            end
        end
    end

    task automatic send_beat(logic [BYTE_W-1:0] b, logic se);
        int gap;
        if (!no_idle && $urandom_range(0, 99) < 22) begin
            i_valid <= 1'b0;
            gap = $urandom_range(1, 3);
            repeat (gap) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_data_byte  <= b;
        i_stream_end <= se;
        do @(posedge i_clk); while (!o_ready);
        predict_extract(b, se);
        beats_sent++;
    endtask

    task automatic send_text(string s, logic end_last);
        for (int i = 0; i < s.len(); i++)
            send_beat(s[i], end_last && (i == s.len() - 1));
    endtask

    // lower valid, let every pending result drain, then cover in-flight bytes
    task automatic drain_results();
        int guard;
        guard = 0;
        i_valid <= 1'b0;
        while (pending_extract.size() != 0 && guard < 20000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_window(logic [CFG_DATA_W-1:0] b, logic [CFG_DATA_W-1:0] e);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_BEGIN_POS;
        i_cfg_data <= b;
        @(posedge i_clk);
        win_begin   = b;
        i_cfg_idx  <= REG_END_POS;
        i_cfg_data <= e;
        @(posedge i_clk);
        win_end     = e;
        i_cfg_we   <= 1'b0;
        windows_used++;
    endtask

    // records of random shape; noise runs and broken lines mixed in
    task automatic send_stream(int n_records);
        logic [BYTE_W-1:0] text_q[$];
        logic [BYTE_W-1:0] c;
        string             alphabet;
        int                n_lines;
        int                n_res;
        logic              end_flag;
        alphabet = "ACGTN";
        if ($urandom_range(0, 5) == 0) begin
            repeat ($urandom_range(1, 4)) text_q.push_back(alphabet[$urandom_range(0, 4)]);
            text_q.push_back(CHAR_LF);
        end
        repeat (n_records) begin
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 8)) text_q.push_back(BYTE_W'($urandom_range(0, 255)));
            end else begin
                text_q.push_back(CHAR_GT);
                repeat ($urandom_range(0, 6)) begin
                    c = ($urandom_range(0, 3) == 0) ? BYTE_W'($urandom_range(0, 255))
                                                    : BYTE_W'($urandom_range(32, 126));
                    text_q.push_back((c == CHAR_LF) ? CHAR_GT : c);
                end
                text_q.push_back(CHAR_LF);
                n_lines = $urandom_range(0, 4);
                for (int l = 0; l < n_lines; l++) begin
                    n_res = $urandom_range(1, 12);
                    repeat (n_res) begin
                        if ($urandom_range(0, 15) == 0)
                            text_q.push_back(BYTE_W'($urandom_range(0, 255)));
                        else
                            text_q.push_back(alphabet[$urandom_range(0, 4)]);
                    end
                    if ($urandom_range(0, 7) == 0) text_q.push_back(8'h0D);
                    if (l != n_lines - 1 || $urandom_range(0, 3) != 0)
                        text_q.push_back(CHAR_LF);
                end
            end
        end
        end_flag = 1'($urandom_range(0, 1));
        foreach (text_q[i])
            send_beat(text_q[i], (end_flag && i == text_q.size() - 1) ||
                                 ($urandom_range(0, 99) == 0));
    endtask

    task automatic test_directed_window();
        // swapped bounds give [2,5); text ahead of the first header is skipped;
        // a header mid-window closes early; stream end lands on a window residue
        set_window(32'd5, 32'd2);
        send_text("A\n>h\nAC\015G\n>\nAC\n>\nAC", 1'b1);
        drain_results();
    endtask

    task automatic test_position_zero();
        // a zero start acts like one; stream end on a line feed closes with a marker
        set_window(32'd0, 32'd4);
        send_text(">\nABC\n>\nAB\n", 1'b1);
        drain_results();
    endtask

    task automatic test_window_extremes();
        logic [CFG_DATA_W-1:0] ext_b[5];
        logic [CFG_DATA_W-1:0] ext_e[5];
        ext_b = '{32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFE};
        ext_e = '{32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF};
        for (int i = 0; i < 5; i++) begin
            set_window(ext_b[i], ext_e[i]);
            send_stream(2);
            drain_results();
        end
    endtask

    task automatic test_random_streams();
        int                    phase;
        logic [CFG_DATA_W-1:0] a;
        logic [CFG_DATA_W-1:0] b;
        phase = 0;
        while (beats_sent < 1000) begin
            case ($urandom_range(0, 7))
                0: begin
                    a = $urandom;
                    b = $urandom;
                end
                1: begin
                    a = $urandom_range(0, 20);
                    b = a;
                end
                default: begin
                    a = $urandom_range(0, 20);
                    b = $urandom_range(0, 40);
                end
            endcase
            if ($urandom_range(0, 1)) set_window(a, b);
            else                      set_window(b, a);
            // a stretch of phases with neither side idling
            no_idle = (phase >= 3 && phase <= 5);
            send_stream($urandom_range(1, 5));
            drain_results();
            phase++;
        end
        no_idle = 1'b0;
    endtask

    initial begin
        clear_parse();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_window();
        test_position_zero();
        test_window_extremes();
        test_random_streams();
        drain_results();
        if (pending_extract.size() != 0) begin
            $error("%0d expected result beats never arrived", pending_extract.size());
            err_count += pending_extract.size();
        end
        $display("sent %0d text beats, checked %0d result beats", beats_sent, results_seen);
        $display("across %0d window settings incl. swapped, empty and full-range", windows_used);
        if (err_count == 0) begin
            $display("[fasta_subsequence_extract_unit] OK");
        end else begin
            $display("[fasta_subsequence_extract_unit] ERROR");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/fse_pkg.sv
rtl/core/fse_window.sv
rtl/core/fasta_subsequence_extract_unit.sv
tb/fasta_subsequence_extract_unit_tb.sv
